>>> rtl/scm_pkg.sv
// Shared types, constants and the microcode table of the servo current model.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package scm_pkg;

    // Field widths
    localparam int US_W      = 16;
    localparam int MA_W      = 12;
    localparam int NOISE_W   = 10;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 24;
    localparam int CUR_W     = 14;
    localparam int REACH_W   = 48;
    localparam int AMPS_W    = 16;
    localparam int DIVIDEND_W = MA_W + US_W;
    localparam int DIV_STEPS = DIVIDEND_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] LCG_MUL   = 32'd1664525;
    localparam logic [TIME_W-1:0] LCG_ADD   = 32'd1013904223;
    localparam logic [TIME_W-1:0] SEED_INIT = 32'h5A17C0DE;
    localparam logic [CUR_W-1:0]  CURRENT_MAX = 14'd16383;

    localparam logic [US_W-1:0] STIFF_LOW_US   = 16'd0;
    localparam logic [US_W-1:0] STIFF_HIGH_US  = 16'd0;
    localparam logic [MA_W-1:0] STIFF_EXTRA_MA = 12'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_MA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_MA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_SPAN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_MA  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SPAN = 3'd7;

    typedef struct packed {
        logic [US_W-1:0]    stop_low_us;
        logic [US_W-1:0]    stop_high_us;
        logic [MA_W-1:0]    free_current_ma;
        logic [MA_W-1:0]    stall_current_ma;
        logic [US_W-1:0]    bind_span_us;
        logic [MA_W-1:0]    travel_current_ma;
        logic [US_W-1:0]    slew_q8;
        logic [NOISE_W-1:0] noise_span_ma;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stop_low_us:       16'd1150,
        stop_high_us:      16'd1880,
        free_current_ma:   12'd120,
        stall_current_ma:  12'd2400,
        bind_span_us:      16'd45,
        travel_current_ma: 12'd950,
        slew_q8:           16'd307,
        noise_span_ma:     10'd20
    };

    // Microcode
    typedef logic [3:0] op_t;
    typedef logic [2:0] cond_t;
    typedef logic [3:0] pc_t;

    localparam op_t OP_NOP    = 4'd0;
    localparam op_t OP_INIT   = 4'd1;
    localparam op_t OP_DT     = 4'd2;
    localparam op_t OP_REACH  = 4'd3;
    localparam op_t OP_MOVE   = 4'd4;
    localparam op_t OP_SEED   = 4'd5;
    localparam op_t OP_NOISE  = 4'd6;
    localparam op_t OP_PREP   = 4'd7;
    localparam op_t OP_DIV    = 4'd8;
    localparam op_t OP_BIND   = 4'd9;
    localparam op_t OP_TRAVEL = 4'd10;
    localparam op_t OP_FREE   = 4'd11;
    localparam op_t OP_FINISH = 4'd12;

    localparam cond_t C_NONE     = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_MOVING   = 3'd2;
    localparam cond_t C_NO_OVER  = 3'd3;
    localparam cond_t C_DIV_BUSY = 3'd4;

    localparam pc_t S_INIT   = 4'd0;
    localparam pc_t S_DT     = 4'd1;
    localparam pc_t S_REACH  = 4'd2;
    localparam pc_t S_MOVE   = 4'd3;
    localparam pc_t S_SEED   = 4'd4;
    localparam pc_t S_NOISE  = 4'd5;
    localparam pc_t S_PREP   = 4'd6;
    localparam pc_t S_DIV    = 4'd7;
    localparam pc_t S_BIND   = 4'd8;
    localparam pc_t S_TRAVEL = 4'd9;
    localparam pc_t S_FREE   = 4'd10;
    localparam pc_t S_FINISH = 4'd11;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  last;
    } ucode_t;

    typedef struct packed {
        logic arrived;
        logic no_over;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode(input pc_t pc);
        ucode_t w;
        unique case (pc)
            S_INIT:   w = '{OP_INIT,   C_NONE,     S_INIT,   1'b0};
            S_DT:     w = '{OP_DT,     C_NONE,     S_INIT,   1'b0};
            S_REACH:  w = '{OP_REACH,  C_NONE,     S_INIT,   1'b0};
            S_MOVE:   w = '{OP_MOVE,   C_NONE,     S_INIT,   1'b0};
            S_SEED:   w = '{OP_SEED,   C_NONE,     S_INIT,   1'b0};
            S_NOISE:  w = '{OP_NOISE,  C_MOVING,   S_TRAVEL, 1'b0};
            S_PREP:   w = '{OP_PREP,   C_NO_OVER,  S_FREE,   1'b0};
            S_DIV:    w = '{OP_DIV,    C_DIV_BUSY, S_DIV,    1'b0};
            S_BIND:   w = '{OP_BIND,   C_ALWAYS,   S_FINISH, 1'b0};
            S_TRAVEL: w = '{OP_TRAVEL, C_ALWAYS,   S_FINISH, 1'b0};
            S_FREE:   w = '{OP_FREE,   C_NONE,     S_INIT,   1'b0};
            S_FINISH: w = '{OP_FINISH, C_NONE,     S_INIT,   1'b1};
            default:  w = '{OP_NOP,    C_NONE,     S_INIT,   1'b1};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/scm_cfg_regs.sv
// Configuration register file of the servo current model.
// Depends on scm_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module scm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output scm_pkg::cfg_t                    cfg
);

    scm_pkg::cfg_t cfg_reg;
    scm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                scm_pkg::REG_STOP_LOW:   cfg_next.stop_low_us       = cfg_data;
                scm_pkg::REG_STOP_HIGH:  cfg_next.stop_high_us      = cfg_data;
                scm_pkg::REG_FREE_MA:    cfg_next.free_current_ma   = cfg_data[11:0];
                scm_pkg::REG_STALL_MA:   cfg_next.stall_current_ma  = cfg_data[11:0];
                scm_pkg::REG_BIND_SPAN:  cfg_next.bind_span_us      = cfg_data;
                scm_pkg::REG_TRAVEL_MA:  cfg_next.travel_current_ma = cfg_data[11:0];
                scm_pkg::REG_SLEW:       cfg_next.slew_q8           = cfg_data;
                scm_pkg::REG_NOISE_SPAN: cfg_next.noise_span_ma     = cfg_data[9:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= scm_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/scm_seq.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on scm_pkg for the microcode table and control types.
`timescale 1ns / 1ps

module scm_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  scm_pkg::status_t  status,
    output logic              idle,
    output scm_pkg::op_t      op
);

    logic            busy_reg;
    logic            busy_next;
    scm_pkg::pc_t    pc_reg;
    scm_pkg::pc_t    pc_next;
    scm_pkg::ucode_t word;
    logic            take;
    logic            stall;

    assign word  = scm_pkg::ucode(pc_reg);
    assign idle  = !busy_reg;
    // hold the last step until the output register can take the result
    assign stall = word.last && !status.out_free;
    assign op    = (busy_reg && !stall) ? word.op : scm_pkg::OP_NOP;

    always_comb
    begin
        unique case (word.cond)
            scm_pkg::C_NONE:     take = 1'b0;
            scm_pkg::C_ALWAYS:   take = 1'b1;
            scm_pkg::C_MOVING:   take = !status.arrived;
            scm_pkg::C_NO_OVER:  take = status.no_over;
            scm_pkg::C_DIV_BUSY: take = status.div_busy;
            default:             take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = scm_pkg::S_INIT;
        end
        else if (busy_reg)
        begin
            if (word.last)
            begin
                if (!stall)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (take)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= scm_pkg::S_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && stall) |=> (busy_reg && pc_reg == $past(pc_reg)))
        else $error("step counter moved while the result was stalled");
`endif

endmodule

>>> rtl/scm_datapath.sv
// Datapath of the servo current model: position slew, LCG noise, bit-serial
// bind divider and output register. Driven by scm_seq; depends on scm_pkg.
`timescale 1ns / 1ps

module scm_datapath #(
    parameter logic [scm_pkg::US_W-1:0] STIFF_LOW_US   = scm_pkg::STIFF_LOW_US,
    parameter logic [scm_pkg::US_W-1:0] STIFF_HIGH_US  = scm_pkg::STIFF_HIGH_US,
    parameter logic [scm_pkg::MA_W-1:0] STIFF_EXTRA_MA = scm_pkg::STIFF_EXTRA_MA
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scm_pkg::cfg_t                     cfg,
    input  logic                              in_load,
    input  logic [scm_pkg::US_W-1:0]          command_us,
    input  logic [scm_pkg::TIME_W-1:0]        time_ms,
    input  scm_pkg::op_t                      op,
    output scm_pkg::status_t                  status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [scm_pkg::CUR_W-1:0]         current_ma,
    output logic [scm_pkg::POS_W-1:0]         position_q8,
    output logic                              arrived
);

    localparam int US_W   = scm_pkg::US_W;
    localparam int MA_W   = scm_pkg::MA_W;
    localparam int POS_W  = scm_pkg::POS_W;
    localparam int AMPS_W = scm_pkg::AMPS_W;
    localparam int DVD_W  = scm_pkg::DIVIDEND_W;
    localparam int NPROD_W = 16 + scm_pkg::NOISE_W;

    // Persistent model state
    logic                            started_reg, started_next;
    logic [scm_pkg::TIME_W-1:0]      prev_reg, prev_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [scm_pkg::TIME_W-1:0]      seed_reg, seed_next;
    // Per-item working registers
    logic [US_W-1:0]                 cmd_reg, cmd_next;
    logic [scm_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [scm_pkg::TIME_W-1:0]      dt_reg, dt_next;
    logic [US_W-1:0]                 tgt_reg, tgt_next;
    logic [US_W-1:0]                 over_reg, over_next;
    logic [scm_pkg::REACH_W-1:0]     reach_reg, reach_next;
    logic                            arrived_reg, arrived_next;
    logic [NPROD_W-1:0]              nprod_reg, nprod_next;
    logic                            neg_reg, neg_next;
    logic [US_W-1:0]                 rem_reg, rem_next;
    logic [DVD_W-1:0]                quo_reg, quo_next;
    logic [scm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [AMPS_W-1:0]        amps_reg, amps_next;
    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic [scm_pkg::CUR_W-1:0]       out_cur_reg, out_cur_next;
    logic [POS_W-1:0]                out_pos_reg, out_pos_next;
    logic                            out_arr_reg, out_arr_next;

    // Combinational helpers
    logic [US_W:0]                   stop_sum;
    logic [POS_W-1:0]                tgt_q8;
    logic [POS_W-1:0]                gap_q8;
    logic                            up;
    logic                            reach_ok;
    logic [scm_pkg::REACH_W-1:0]     reach_prod;
    logic [scm_pkg::TIME_W-1:0]      seed_prod;
    logic [NPROD_W-1:0]              noise_prod;
    logic [US_W-1:0]                 bind_eff;
    logic [US_W-1:0]                 bind_min;
    logic [MA_W-1:0]                 diff_mag;
    logic [DVD_W-1:0]                bind_prod;
    logic [US_W:0]                   trial;
    logic [US_W:0]                   shifted;
    logic signed [AMPS_W-1:0]        quot_s;
    logic signed [AMPS_W-1:0]        noise_s;
    logic signed [AMPS_W-1:0]        stiff_s;
    logic signed [AMPS_W-1:0]        total;
    logic                            stiff_hit;
    logic                            out_free;

    assign out_free = !out_valid_reg || out_ready;

    assign status.arrived  = arrived_reg;
    assign status.no_over  = (over_reg == '0);
    assign status.div_busy = (cnt_reg != scm_pkg::DIV_CNT_W'(scm_pkg::DIV_STEPS - 1));
    assign status.out_free = out_free;

    assign out_valid   = out_valid_reg;
    assign current_ma  = out_cur_reg;
    assign position_q8 = out_pos_reg;
    assign arrived     = out_arr_reg;

    assign stop_sum = {1'b0, cfg.stop_low_us} + {1'b0, cfg.stop_high_us};
    assign tgt_q8   = {tgt_reg, 8'h00};
    assign up       = (tgt_q8 > pos_reg);
    assign gap_q8   = up ? (tgt_q8 - pos_reg) : (pos_reg - tgt_q8);
    assign reach_ok = ({{(scm_pkg::REACH_W - POS_W){1'b0}}, gap_q8} <= reach_reg);

    assign reach_prod = cfg.slew_q8 * dt_reg;
    assign seed_prod  = seed_reg * scm_pkg::LCG_MUL;
    assign noise_prod = seed_reg[23:8] * cfg.noise_span_ma;

    assign bind_eff  = (cfg.bind_span_us == '0) ? US_W'(1) : cfg.bind_span_us;
    assign bind_min  = (over_reg < bind_eff) ? over_reg : bind_eff;
    assign diff_mag  = (cfg.stall_current_ma >= cfg.free_current_ma)
                     ? (cfg.stall_current_ma - cfg.free_current_ma)
                     : (cfg.free_current_ma - cfg.stall_current_ma);
    assign bind_prod = diff_mag * bind_min;

    // one restoring division step: bring down the next dividend bit
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, bind_eff};

    assign quot_s  = $signed({{(AMPS_W - MA_W){1'b0}}, quo_reg[MA_W-1:0]});
    assign noise_s = $signed({{(AMPS_W - scm_pkg::NOISE_W){1'b0}},
                              nprod_reg[NPROD_W-1:16]})
                   - $signed({{(AMPS_W - scm_pkg::NOISE_W + 1){1'b0}},
                              cfg.noise_span_ma[scm_pkg::NOISE_W-1:1]});
    assign stiff_hit = arrived_reg && (STIFF_HIGH_US > STIFF_LOW_US)
                     && (cmd_reg >= STIFF_LOW_US) && (cmd_reg <= STIFF_HIGH_US);
    assign stiff_s = stiff_hit ? $signed({{(AMPS_W - MA_W){1'b0}}, STIFF_EXTRA_MA})
                               : '0;
    assign total   = amps_reg + stiff_s + noise_s;

    always_comb
    begin
        started_next   = started_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        seed_next      = seed_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        dt_next        = dt_reg;
        tgt_next       = tgt_reg;
        over_next      = over_reg;
        reach_next     = reach_reg;
        arrived_next   = arrived_reg;
        nprod_next     = nprod_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        amps_next      = amps_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cur_next   = out_cur_reg;
        out_pos_next   = out_pos_reg;
        out_arr_next   = out_arr_reg;

        if (in_load)
        begin
            cmd_next = command_us;
            now_next = time_ms;
        end

        unique case (op)
            scm_pkg::OP_INIT:
            begin
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    prev_next    = now_reg;
                    pos_next     = {stop_sum[US_W:1], 8'h00};
                end
            end
            scm_pkg::OP_DT:
            begin
                dt_next   = now_reg - prev_reg;
                prev_next = now_reg;
                if (cmd_reg > cfg.stop_high_us)
                begin
                    tgt_next  = cfg.stop_high_us;
                    over_next = cmd_reg - cfg.stop_high_us;
                end
                else if (cmd_reg < cfg.stop_low_us)
                begin
                    tgt_next  = cfg.stop_low_us;
                    over_next = cfg.stop_low_us - cmd_reg;
                end
                else
                begin
                    tgt_next  = cmd_reg;
                    over_next = '0;
                end
            end
            scm_pkg::OP_REACH:
            begin
                reach_next = reach_prod;
            end
            scm_pkg::OP_MOVE:
            begin
                arrived_next = reach_ok;
                if (reach_ok)
                begin
                    pos_next = tgt_q8;
                end
                else if (up)
                begin
                    pos_next = pos_reg + reach_reg[POS_W-1:0];
                end
                else
                begin
                    pos_next = pos_reg - reach_reg[POS_W-1:0];
                end
            end
            scm_pkg::OP_SEED:
            begin
                seed_next = seed_prod + scm_pkg::LCG_ADD;
            end
            scm_pkg::OP_NOISE:
            begin
                nprod_next = noise_prod;
            end
            scm_pkg::OP_PREP:
            begin
                neg_next = (cfg.stall_current_ma < cfg.free_current_ma);
                quo_next = bind_prod;
                rem_next = '0;
                cnt_next = '0;
            end
            scm_pkg::OP_DIV:
            begin
                if (!trial[US_W])
                begin
                    rem_next = trial[US_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[US_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + scm_pkg::DIV_CNT_W'(1);
            end
            scm_pkg::OP_BIND:
            begin
                amps_next = $signed({{(AMPS_W - MA_W){1'b0}}, cfg.free_current_ma})
                          + (neg_reg ? -quot_s : quot_s);
            end
            scm_pkg::OP_TRAVEL:
            begin
                amps_next = $signed({{(AMPS_W - MA_W){1'b0}}, cfg.travel_current_ma});
            end
            scm_pkg::OP_FREE:
            begin
                amps_next = $signed({{(AMPS_W - MA_W){1'b0}}, cfg.free_current_ma});
            end
            scm_pkg::OP_FINISH:
            begin
                out_valid_next = 1'b1;
                out_pos_next   = pos_reg;
                out_arr_next   = arrived_reg;
                if (total < 0)
                begin
                    out_cur_next = '0;
                end
                else if (total > $signed({{(AMPS_W - scm_pkg::CUR_W){1'b0}},
                                          scm_pkg::CURRENT_MAX}))
                begin
                    out_cur_next = scm_pkg::CURRENT_MAX;
                end
                else
                begin
                    out_cur_next = total[scm_pkg::CUR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            prev_reg      <= '0;
            pos_reg       <= '0;
            seed_reg      <= scm_pkg::SEED_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        dt_reg      <= dt_next;
        tgt_reg     <= tgt_next;
        over_reg    <= over_next;
        reach_reg   <= reach_next;
        arrived_reg <= arrived_next;
        nprod_reg   <= nprod_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        amps_reg    <= amps_next;
        out_cur_reg <= out_cur_next;
        out_pos_reg <= out_pos_next;
        out_arr_reg <= out_arr_next;
    end

`ifndef SYNTHESIS
    a_arrived_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (op == scm_pkg::OP_MOVE) |=> (arrived_reg == (pos_reg == {tgt_reg, 8'h00})))
        else $error("arrived flag disagrees with the new position");
    a_quotient_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (op == scm_pkg::OP_BIND) |-> (quo_reg[DVD_W-1:MA_W] == '0))
        else $error("bind quotient exceeds the current difference");
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op == scm_pkg::OP_FINISH))
        else $error("result raised outside the finish step");
`endif

endmodule

>>> rtl/servo_current_model_step.sv
// Top level of the servo current model: stream ports, configuration port,
// and the sequencer, datapath and register file; depends on scm_pkg.
`timescale 1ns / 1ps

// Servo supply-current model. One request (command pulse width and millisecond
// timestamp) yields one result (current in mA, Q8 position, arrived flag).
// A microcoded sequencer runs one step per cycle, except that its last step
// waits while the output register cannot take the result. A request takes the
// travel current while the horn is moving and the free current once it has
// arrived; if it is also pushed past a stop, a bit-serial divider works out
// the bind share. The input is taken only while the sequencer is idle; a
// finished result waits in the output register while the next request is
// accepted. Configuration writes are always accepted and must be made while no request is in flight.
module servo_current_model_step #(
    parameter logic [scm_pkg::US_W-1:0] STIFF_LOW_US   = scm_pkg::STIFF_LOW_US,
    parameter logic [scm_pkg::US_W-1:0] STIFF_HIGH_US  = scm_pkg::STIFF_HIGH_US,
    parameter logic [scm_pkg::MA_W-1:0] STIFF_EXTRA_MA = scm_pkg::STIFF_EXTRA_MA
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] command_us, [47:16] time_ms
    input  logic [scm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [13:0] current_ma, [37:14] position_q8, [38] arrived, [39] zero
    output logic [scm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    scm_pkg::cfg_t                   cfg;
    scm_pkg::status_t                status;
    scm_pkg::op_t                    op;
    logic                            idle;
    logic                            in_accept;
    logic [scm_pkg::CUR_W-1:0]       current_ma;
    logic [scm_pkg::POS_W-1:0]       position_q8;
    logic                            arrived;

    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && idle;
    assign m_axis_tdata  = {1'b0, arrived, position_q8, current_ma};

    scm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .status (status),
        .idle   (idle),
        .op     (op)
    );

    scm_datapath #(
        .STIFF_LOW_US   (STIFF_LOW_US),
        .STIFF_HIGH_US  (STIFF_HIGH_US),
        .STIFF_EXTRA_MA (STIFF_EXTRA_MA)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_load     (in_accept),
        .command_us  (s_axis_tdata[15:0]),
        .time_ms     (s_axis_tdata[47:16]),
        .op          (op),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .current_ma  (current_ma),
        .position_q8 (position_q8),
        .arrived     (arrived)
    );

endmodule
